### hdl/vrds_pkg.sv
// ----------------------------------------------------------------------------
// vrds_pkg
// Types and constants shared by the VP8 RTP descriptor stripper and its
// channel interfaces.
// ----------------------------------------------------------------------------
package vrds_pkg;

    localparam int unsigned ByteW  = 8;
    localparam int unsigned CountW = 16;
    localparam int unsigned StatW  = 2;

    localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

    // Descriptor bit masks
    localparam logic [ByteW-1:0] BitHi = 8'h80;
    localparam logic [ByteW-1:0] BitL  = 8'h40;
    localparam logic [ByteW-1:0] BitT  = 8'h20;
    localparam logic [ByteW-1:0] BitK  = 8'h10;

    // Packet status codes
    localparam logic [StatW-1:0] StatOk         = 2'd0;
    localparam logic [StatW-1:0] StatIncomplete = 2'd1;
    localparam logic [StatW-1:0] StatOverflow   = 2'd2;

    typedef struct packed {
        logic [ByteW-1:0] packet_byte;
        logic             last_byte;
    } in_item_t;

    typedef struct packed {
        logic [ByteW-1:0]  out_byte;
        logic              byte_valid;
        logic              packet_end;
        logic [StatW-1:0]  status;
        logic [CountW-1:0] payload_length;
    } out_item_t;

endpackage

### hdl/vrds_channels.sv
// ----------------------------------------------------------------------------
// vrds channels
// Valid/ready channel interfaces for packet bytes in and results out.
// ----------------------------------------------------------------------------
interface vrds_in_if;
    logic               valid;
    logic               ready;
    vrds_pkg::in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface vrds_out_if;
    logic                valid;
    logic                ready;
    vrds_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

### hdl/vp8_rtp_descriptor_stripper.sv
// ----------------------------------------------------------------------------
// vp8_rtp_descriptor_stripper
// Strips the VP8 RTP payload descriptor and passes payload bytes through.
// ----------------------------------------------------------------------------
// Usage:
//   byte_in carries one packet byte per transfer, last_byte set on the final
//   byte. result_out carries at most one result per input byte: a payload
//   byte, or a closing result with packet_end, status and payload_length.
//   Non-final descriptor bytes and dropped non-final bytes give no result.
//   cfg_write_en / cfg_write_data load the capacity register (reset 65535);
//   write it only while no packet is in flight.
// Timing:
//   One byte per cycle sustained while result_out does not stall. A byte
//   lands in the input register at its transfer, and its result is then
//   written to the output register. Between them the per-byte parse is one
//   phase update, a 16-bit capacity compare and a saturating increment.
// Reset / stall:
//   Reset clears the parse state, empties both registers and sets capacity
//   to 65535. When result_out stalls, the result holds, the input register
//   fills, and byte_in.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module vp8_rtp_descriptor_stripper
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write_en,
    input  logic [vrds_pkg::CountW-1:0]  cfg_write_data,
    vrds_in_if.sink                      byte_in,
    vrds_out_if.source                   result_out
);

    typedef enum logic [2:0] {
        PH_FIRST,
        PH_EXT,
        PH_PID1,
        PH_PID2,
        PH_TL0,
        PH_TIDKEY,
        PH_PAYLOAD
    } phase_t;

    logic [vrds_pkg::CountW-1:0] capacity_reg;

    logic                        in_valid_reg;
    vrds_pkg::in_item_t          in_item_reg;
    logic                        out_valid_reg, out_valid_next;
    vrds_pkg::out_item_t         out_item_reg, out_item_next;

    phase_t                      phase_reg, phase_next;
    logic                        want_tl0_reg, want_tl0_next;
    logic                        want_tk_reg, want_tk_next;
    logic [vrds_pkg::CountW-1:0] count_reg, count_next;
    logic                        ovf_reg, ovf_next;

    logic                        advance;
    logic                        take_in;
    logic                        fits;
    logic [vrds_pkg::CountW-1:0] count_inc;
    logic                        do_emit;
    phase_t                      desc_next;
    logic                        tl0_sel, tk_sel;

    assign advance        = in_valid_reg && (!out_valid_reg || result_out.ready);
    assign take_in        = byte_in.valid && byte_in.ready;
    assign byte_in.ready  = !in_valid_reg || advance;
    assign result_out.valid = out_valid_reg;
    assign result_out.item  = out_item_reg;

    assign fits      = count_reg < capacity_reg;
    assign count_inc = (count_reg < vrds_pkg::CountMax) ? count_reg + 16'd1 : count_reg;

    // Descriptor phase walk
    always_comb
    begin
        tl0_sel   = want_tl0_reg;
        tk_sel    = want_tk_reg;
        desc_next = PH_PAYLOAD;
        case (phase_reg)
            PH_FIRST:
            begin
                desc_next = |(in_item_reg.packet_byte & vrds_pkg::BitHi) ? PH_EXT : PH_PAYLOAD;
            end
            PH_EXT:
            begin
                tl0_sel = |(in_item_reg.packet_byte & vrds_pkg::BitL);
                tk_sel  = |(in_item_reg.packet_byte & (vrds_pkg::BitT | vrds_pkg::BitK));
                if (|(in_item_reg.packet_byte & vrds_pkg::BitHi))
                    desc_next = PH_PID1;
                else if (tl0_sel)
                    desc_next = PH_TL0;
                else if (tk_sel)
                    desc_next = PH_TIDKEY;
                else
                    desc_next = PH_PAYLOAD;
            end
            PH_PID1, PH_PID2:
            begin
                if (phase_reg == PH_PID1 &&
                    |(in_item_reg.packet_byte & vrds_pkg::BitHi))
                    desc_next = PH_PID2;
                else if (want_tl0_reg)
                    desc_next = PH_TL0;
                else if (want_tk_reg)
                    desc_next = PH_TIDKEY;
                else
                    desc_next = PH_PAYLOAD;
            end
            PH_TL0:
            begin
                desc_next = want_tk_reg ? PH_TIDKEY : PH_PAYLOAD;
            end
            default:
            begin
                desc_next = PH_PAYLOAD;
            end
        endcase
    end

    // Next state and result
    always_comb
    begin
        phase_next     = phase_reg;
        want_tl0_next  = want_tl0_reg;
        want_tk_next   = want_tk_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        do_emit        = 1'b0;
        out_item_next  = '0;

        if (phase_reg == PH_PAYLOAD)
        begin
            count_next = count_inc;
            ovf_next   = ovf_reg || !fits;
            do_emit    = fits || in_item_reg.last_byte;
            out_item_next.out_byte       = fits ? in_item_reg.packet_byte : 8'd0;
            out_item_next.byte_valid     = fits;
            out_item_next.packet_end     = in_item_reg.last_byte;
            out_item_next.status         = (in_item_reg.last_byte && ovf_next) ?
                                           vrds_pkg::StatOverflow : vrds_pkg::StatOk;
            out_item_next.payload_length = count_inc;
        end
        else
        begin
            phase_next    = desc_next;
            want_tl0_next = tl0_sel;
            want_tk_next  = tk_sel;
            do_emit       = in_item_reg.last_byte;
            out_item_next.packet_end = 1'b1;
            out_item_next.status     = (desc_next == PH_PAYLOAD) ?
                                       vrds_pkg::StatOk : vrds_pkg::StatIncomplete;
        end

        // Return to packet start after the closing byte
        if (in_item_reg.last_byte)
        begin
            phase_next    = PH_FIRST;
            want_tl0_next = 1'b0;
            want_tk_next  = 1'b0;
            count_next    = '0;
            ovf_next      = 1'b0;
        end

        if (advance && do_emit)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= vrds_pkg::CountMax;
            in_valid_reg  <= 1'b0;
            in_item_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
            phase_reg     <= PH_FIRST;
            want_tl0_reg  <= 1'b0;
            want_tk_reg   <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
                capacity_reg <= cfg_write_data;
            if (take_in)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (take_in)
                in_item_reg <= byte_in.item;
            out_valid_reg <= out_valid_next;
            if (advance && do_emit)
                out_item_reg <= out_item_next;
            if (advance)
            begin
                phase_reg    <= phase_next;
                want_tl0_reg <= want_tl0_next;
                want_tk_reg  <= want_tk_next;
                count_reg    <= count_next;
                ovf_reg      <= ovf_next;
            end
        end
    end

    // Checks
    a_nonbyte_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_item_reg.byte_valid |-> out_item_reg.packet_end)
        else $error("result without byte does not close packet");

    a_incomplete_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.status == vrds_pkg::StatIncomplete
        |-> out_item_reg.payload_length == '0 && !out_item_reg.byte_valid)
        else $error("incomplete descriptor result carries payload");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_item_reg.last_byte
        |=> phase_reg == PH_FIRST && count_reg == '0 && !ovf_reg)
        else $error("state not cleared after closing byte");

    a_byte_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_item_reg.byte_valid
        |-> out_item_reg.status == vrds_pkg::StatOk && out_item_reg.payload_length != '0)
        else $error("passed byte has bad status or length");

endmodule
